// ===== hdl/eas_pkg.sv =====
// shared types and constants for the edge attribute stepper
// no dependencies; imported by eas_ctrl, eas_datapath and edge_attribute_stepper

package eas_pkg;

  localparam int NUM_ATTRS = 6;
  localparam int IDX_W     = 3;
  localparam int FIELD_W   = 32;
  localparam int STEP_W    = 32;
  localparam int CHUNK_W   = 16;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SETUP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP       = 2'd2;

  // beat layout
  localparam int AXIS_BIT  = 0;
  localparam int ATTR_LSB  = 1;
  localparam int STEP_LSB  = ATTR_LSB + NUM_ATTRS * FIELD_W;
  localparam int S_TDATA_W = 232;
  localparam int S_TUSER_W = MODE_W;
  localparam int M_TDATA_W = NUM_ATTRS * FIELD_W;
  localparam int M_TUSER_W = 1;

  typedef struct packed {
    logic             capture;
    logic             load_start;
    logic             delta_load;
    logic             zero_setup;
    logic             div_init;
    logic             div_step;
    logic             div_write;
    logic             mul_lo;
    logic             mul_hi;
    logic             mul_write;
    logic             load_out;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              axis_y;
    logic              delta_zero;
  } dp_status_t;

endpackage

// ===== hdl/eas_ctrl.sv =====
// sequencing state machine for the edge attribute stepper
// depends on eas_pkg; drives eas_datapath through dp_cmd_t

module eas_ctrl
  import eas_pkg::*;
#(
  parameter int ATTR_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int DIV_STEPS = ATTR_WIDTH + FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ATTRS - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_DELTA  = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_DINIT  = 4'd4;
  localparam logic [3:0] ST_DSTEP  = 4'd5;
  localparam logic [3:0] ST_DWRITE = 4'd6;
  localparam logic [3:0] ST_MLO    = 4'd7;
  localparam logic [3:0] ST_MHI    = 4'd8;
  localparam logic [3:0] ST_MWRITE = 4'd9;
  localparam logic [3:0] ST_RESULT = 4'd10;

  logic [3:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid, out_valid_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cnt_next       = cnt;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    cmd.idx        = idx;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (status.mode == MODE_LOAD_START) begin
          cmd.load_start = 1'b1;
          state_next     = ST_RESULT;
        end else if (status.mode == MODE_SETUP) begin
          idx_next   = IDX_W'(status.axis_y);
          state_next = ST_DELTA;
        end else if (status.mode == MODE_STEP) begin
          idx_next   = '0;
          state_next = ST_MLO;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_DELTA: begin
        cmd.delta_load = 1'b1;
        state_next     = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.delta_zero) begin
          cmd.zero_setup = 1'b1;
          state_next     = ST_RESULT;
        end else begin
          idx_next   = '0;
          state_next = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_DWRITE;
        end
      end
      ST_DWRITE: begin
        cmd.div_write = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_RESULT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_DINIT;
        end
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_MWRITE;
      end
      ST_MWRITE: begin
        cmd.mul_write = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_RESULT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_MLO;
        end
      end
      ST_RESULT: begin
        if (!out_valid || m_tready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/eas_datapath.sv =====
// attribute store, shared restoring divider and chunked multiplier
// depends on eas_pkg; commanded by eas_ctrl

module eas_datapath
  import eas_pkg::*;
#(
  parameter int ATTR_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic [M_TDATA_W-1:0] out_data,
  output logic                 out_flag
);

  localparam int W    = ATTR_WIDTH;
  localparam int NW   = W + 1 + FRAC_BITS;
  localparam int PW   = W + STEP_W;
  localparam int SATW = W + STEP_W + 1;
  localparam int LW   = W + CHUNK_W + 1;

  function automatic logic signed [W-1:0] sat_attr(input logic signed [SATW-1:0] x);
    logic [SATW-W:0] hi;
    hi = x[SATW-1:W-1];
    if ((&hi) || !(|hi)) begin
      return x[W-1:0];
    end
    return x[SATW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  logic signed [W-1:0] start_a [NUM_ATTRS];
  logic signed [W-1:0] cur_a   [NUM_ATTRS];
  logic signed [W-1:0] inc_a   [NUM_ATTRS];
  logic signed [W-1:0] end_a   [NUM_ATTRS];

  logic [MODE_W-1:0]  mode;
  logic               axis_y;
  logic [STEP_W-1:0]  step;
  logic               delta_zero;
  logic               den_neg;
  logic               q_neg;
  logic [W:0]         dmag;
  logic [W:0]         rem;
  logic [NW-1:0]      quo;
  logic signed [PW-1:0] prod;
  logic               flag;

  logic signed [W-1:0] start_sel, end_sel, cur_sel, inc_sel;
  logic signed [W:0]   diff;
  logic [W:0]          diff_mag;
  logic [W+1:0]        rem_shift;
  logic                rem_ge;
  logic signed [NW:0]  q_signed;
  logic signed [LW-1:0] mul_a, mul_lo_b, p_lo;
  logic signed [W+CHUNK_W-1:0] mul_a_hi, mul_hi_b, p_hi;
  logic signed [PW-1:0] prod_shr;
  logic signed [W-1:0]  step_add;
  logic signed [W:0]    step_sum;

  assign start_sel = start_a[cmd.idx];
  assign end_sel   = end_a[cmd.idx];
  assign cur_sel   = cur_a[cmd.idx];
  assign inc_sel   = inc_a[cmd.idx];

  assign diff     = (W+1)'(end_sel) - (W+1)'(start_sel);
  assign diff_mag = diff[W] ? (W+1)'(-diff) : diff;

  assign rem_shift = {rem, quo[NW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dmag});
  assign q_signed  = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign mul_a    = LW'(inc_sel);
  assign mul_lo_b = $signed(LW'({1'b0, step[CHUNK_W-1:0]}));
  assign p_lo     = mul_a * mul_lo_b;
  assign mul_a_hi = (W+CHUNK_W)'(inc_sel);
  assign mul_hi_b = (W+CHUNK_W)'($signed(step[STEP_W-1:CHUNK_W]));
  assign p_hi     = mul_a_hi * mul_hi_b;

  assign prod_shr = prod >>> FRAC_BITS;
  assign step_add = sat_attr(SATW'(prod_shr));
  assign step_sum = (W+1)'(cur_sel) + (W+1)'(step_add);

  assign status.mode       = mode;
  assign status.axis_y     = axis_y;
  assign status.delta_zero = delta_zero;

  // captured beat, divider and multiplier working registers, and the output registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode   <= s_tuser;
      axis_y <= s_tdata[AXIS_BIT];
      step   <= s_tdata[STEP_LSB +: STEP_W];
      for (int i = 0; i < NUM_ATTRS; i++) begin
        end_a[i] <= sat_attr(SATW'($signed(s_tdata[ATTR_LSB + i*FIELD_W +: FIELD_W])));
      end
    end
    if (cmd.delta_load) begin
      den_neg    <= diff[W];
      dmag       <= diff_mag;
      delta_zero <= (diff == '0);
    end
    if (cmd.div_init) begin
      q_neg <= diff[W] ^ den_neg;
      quo   <= {diff_mag, {FRAC_BITS{1'b0}}};
      rem   <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? (W+1)'(rem_shift - {1'b0, dmag}) : rem_shift[W:0];
      quo <= {quo[NW-2:0], rem_ge};
    end
    if (cmd.mul_lo) begin
      prod <= PW'(p_lo);
    end else if (cmd.mul_hi) begin
      prod <= prod + (PW'(p_hi) <<< CHUNK_W);
    end
    if (cmd.load_out) begin
      out_flag <= flag;
      for (int i = 0; i < NUM_ATTRS; i++) begin
        out_data[i*FIELD_W +: FIELD_W] <= FIELD_W'(cur_a[i]);
      end
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
      for (int i = 0; i < NUM_ATTRS; i++) begin
        start_a[i] <= '0;
        cur_a[i]   <= '0;
        inc_a[i]   <= '0;
      end
    end else begin
      if (cmd.capture) begin
        flag <= 1'b0;
      end
      if (cmd.load_start) begin
        for (int i = 0; i < NUM_ATTRS; i++) begin
          start_a[i] <= end_a[i];
          cur_a[i]   <= end_a[i];
        end
      end
      if (cmd.zero_setup) begin
        flag <= 1'b1;
        for (int i = 0; i < NUM_ATTRS; i++) begin
          inc_a[i] <= '0;
          cur_a[i] <= start_a[i];
        end
      end
      if (cmd.div_write) begin
        inc_a[cmd.idx] <= sat_attr(SATW'(q_signed));
        cur_a[cmd.idx] <= start_sel;
      end
      if (cmd.mul_write) begin
        cur_a[cmd.idx] <= sat_attr(SATW'(step_sum));
      end
    end
  end

endmodule

// ===== hdl/edge_attribute_stepper.sv =====
// edge_attribute_stepper: six-attribute edge walker, one beat in and one beat out per item
// a start load or an unused mode goes straight to the result; a set-up divides each attribute
// in turn (shared one-bit-a-cycle divider) unless the span is zero; a step multiplies each
// in turn (16-bit chunk multiplier: low chunk, high chunk, write); one item in flight: the
// next beat is taken the cycle after the result is loaded, so the output register lets it
// in while a result waits; sync active-high reset clears control, start, cur, inc and flag

module edge_attribute_stepper
  import eas_pkg::*;
#(
  parameter int ATTR_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // axis_y, pos_x, pos_y, depth_in, red_in, green_in, blue_in, step_amount, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // cur_x, cur_y, cur_depth, cur_red, cur_green, cur_blue
  output logic [M_TDATA_W-1:0] m_tdata,
  // zero_delta
  output logic [M_TUSER_W-1:0] m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       out_flag;

  eas_ctrl #(
    .ATTR_WIDTH (ATTR_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  eas_datapath #(
    .ATTR_WIDTH (ATTR_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .out_data (m_tdata),
    .out_flag (out_flag)
  );

  assign m_tuser = M_TUSER_W'(out_flag);

endmodule

// ===== tb/edge_attribute_stepper_checker.sv =====
// checker for edge_attribute_stepper: mirrors the edge walk on every accepted input beat
// and compares each output beat, field by field, with the oldest predicted point
// depends on eas_pkg for the beat layout and the mode codes

module edge_attribute_stepper_checker
  import eas_pkg::*;
#(
  parameter int ATTR_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // axis_y, pos_x, pos_y, depth_in, red_in, green_in, blue_in, step_amount, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // cur_x, cur_y, cur_depth, cur_red, cur_green, cur_blue
  input  logic [M_TDATA_W-1:0] m_tdata,
  // zero_delta
  input  logic [M_TUSER_W-1:0] m_tuser,
  output int                   mismatches,
  output int                   pending,
  output int                   beats_checked,
  output int                   start_loads,
  output int                   setups,
  output int                   flat_setups,
  output int                   steps,
  output int                   unused_beats
);

  localparam longint ATTR_HI     = (longint'(1) <<< (ATTR_WIDTH - 1)) - 1;
  localparam longint ATTR_LO     = -ATTR_HI - 1;
  localparam int     MAX_PRINTED = 100;

  typedef struct packed {
    logic                              zero_delta;
    logic [NUM_ATTRS-1:0][FIELD_W-1:0] attrs;
  } edge_point_t;

  longint      start_pt [NUM_ATTRS];
  longint      cur_pt   [NUM_ATTRS];
  longint      incr     [NUM_ATTRS];
  edge_point_t points_due [$];
  string       attr_name [NUM_ATTRS] = '{"cur_x", "cur_y", "cur_depth",
                                         "cur_red", "cur_green", "cur_blue"};

  function automatic longint saturate(input longint v);
    if (v > ATTR_HI) begin
      return ATTR_HI;
    end
    if (v < ATTR_LO) begin
      return ATTR_LO;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch on result %0d: %s got %08h expected %08h",
               beats_checked, what, got, want);
    end
  endtask

  // next point of the edge after one input beat
  task automatic walk_edge(input logic [MODE_W-1:0] mode, input logic [S_TDATA_W-1:0] beat);
    longint      vtx [NUM_ATTRS];
    longint      span;
    longint      stride;
    int          ax;
    int          i;
    edge_point_t pt;
    stride = longint'($signed(beat[STEP_LSB +: STEP_W]));
    ax     = beat[AXIS_BIT] ? 1 : 0;
    for (i = 0; i < NUM_ATTRS; i++) begin
      vtx[i] = saturate(longint'($signed(beat[ATTR_LSB + i*FIELD_W +: FIELD_W])));
    end
    pt = '0;
    case (mode)
      MODE_LOAD_START: begin
        for (i = 0; i < NUM_ATTRS; i++) begin
          start_pt[i] = vtx[i];
          cur_pt[i]   = vtx[i];
        end
        start_loads++;
      end
      MODE_SETUP: begin
        span = vtx[ax] - start_pt[ax];
        for (i = 0; i < NUM_ATTRS; i++) begin
          if (span == 0) begin
            incr[i] = 0;
          end else begin
            incr[i] = saturate(((vtx[i] - start_pt[i]) * (longint'(1) <<< FRAC_BITS)) / span);
          end
          cur_pt[i] = start_pt[i];
        end
        pt.zero_delta = (span == 0);
        setups++;
        if (span == 0) begin
          flat_setups++;
        end
      end
      MODE_STEP: begin
        for (i = 0; i < NUM_ATTRS; i++) begin
          cur_pt[i] = saturate(cur_pt[i] + saturate((incr[i] * stride) >>> FRAC_BITS));
        end
        steps++;
      end
      default: begin
        unused_beats++;
      end
    endcase
    for (i = 0; i < NUM_ATTRS; i++) begin
      pt.attrs[i] = cur_pt[i][FIELD_W-1:0];
    end
    points_due.push_back(pt);
  endtask

  task automatic check_point(input logic [M_TDATA_W-1:0] data,
                             input logic [M_TUSER_W-1:0] flag);
    edge_point_t want;
    int          i;
    if (points_due.size() == 0) begin
      report_mismatch("output beat with nothing due, cur_x", data[FIELD_W-1:0], '0);
    end else begin
      want = points_due.pop_front();
      for (i = 0; i < NUM_ATTRS; i++) begin
        if (data[i*FIELD_W +: FIELD_W] !== want.attrs[i]) begin
          report_mismatch(attr_name[i], data[i*FIELD_W +: FIELD_W], want.attrs[i]);
        end
      end
      if (flag[0] !== want.zero_delta) begin
        report_mismatch("zero_delta", 32'(flag[0]), 32'(want.zero_delta));
      end
    end
    beats_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ATTRS; i++) begin
        start_pt[i] = 0;
        cur_pt[i]   = 0;
        incr[i]     = 0;
      end
      points_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_point(m_tdata, m_tuser);
      end
      if (s_tvalid && s_tready) begin
        walk_edge(s_tuser, s_tdata);
      end
    end
    pending = points_due.size();
  end

endmodule

// ===== tb/edge_attribute_stepper_tb.sv =====
// testbench top for edge_attribute_stepper: drives directed and random edge walks with
// random idling on both sides and gives the verdict
// depends on eas_pkg, edge_attribute_stepper and edge_attribute_stepper_checker

module edge_attribute_stepper_tb;
  import eas_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
  localparam int                 TOTAL_ITEMS = 1900;
  localparam int                 HOLD_AT     = 700;
  localparam int                 CALM_FROM   = 1550;
  localparam int                 HOLD_CYCLES = 500;
  localparam int                 TAIL_CYCLES = 400;
  localparam int                 CYCLE_LIMIT = 3000000;
  localparam logic [FIELD_W-1:0] Q_MAX       = 32'h7fffffff;
  localparam logic [FIELD_W-1:0] Q_MIN       = 32'h80000000;
  localparam logic [FIELD_W-1:0] Q_ONE       = 32'h00010000;
  localparam logic [FIELD_W-1:0] Q_NEG_ONE   = 32'hffff0000;
  localparam logic [FIELD_W-1:0] Q_ULP_DOWN  = 32'hffffffff;

  typedef logic [NUM_ATTRS-1:0][FIELD_W-1:0] vertex_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  int   mismatches;
  int   pending;
  int   beats_checked;
  int   start_loads;
  int   setups;
  int   flat_setups;
  int   steps;
  int   unused_beats;
  int   cycle_count;
  int   beats_sent;
  int   src_idle_pct;
  int   sink_idle_pct;
  logic calm;
  logic hold_req;

  edge_attribute_stepper u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  edge_attribute_stepper_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .mismatches    (mismatches),
    .pending       (pending),
    .beats_checked (beats_checked),
    .start_loads   (start_loads),
    .setups        (setups),
    .flat_setups   (flat_setups),
    .steps         (steps),
    .unused_beats  (unused_beats)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic vertex_t vtx6(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                                   input logic [FIELD_W-1:0] d, input logic [FIELD_W-1:0] r,
                                   input logic [FIELD_W-1:0] g, input logic [FIELD_W-1:0] b);
    return {b, g, r, d, y, x};
  endfunction

  // mostly small coordinates, some full range and some extremes
  function automatic logic [FIELD_W-1:0] pick_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 15))
      0:          return Q_MAX;
      1:          return Q_MIN;
      2:          return '0;
      3, 4, 5, 6: return r;
      default:    return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  function automatic vertex_t pick_vertex();
    vertex_t v;
    for (int i = 0; i < NUM_ATTRS; i++) begin
      v[i] = pick_coord();
    end
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] pick_stride();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 15))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3, 4:    return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 25;
      default: return 50;
    endcase
  endfunction

  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic axis,
                           input vertex_t vtx, input logic [STEP_W-1:0] stride);
    logic [S_TDATA_W-1:0] beat;
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    beat                                  = '0;
    beat[AXIS_BIT]                        = axis;
    beat[ATTR_LSB +: NUM_ATTRS * FIELD_W] = vtx;
    beat[STEP_LSB +: STEP_W]              = stride;
    s_tdata  <= beat;
    s_tuser  <= mode;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // start, set-up and a run of steps, sometimes re-aimed from the same start
  task automatic walk_random_edge();
    vertex_t first;
    vertex_t last;
    logic    axis;
    int      runs;
    int      n;
    first = pick_vertex();
    send_beat(MODE_LOAD_START, 1'($urandom_range(0, 1)), first, pick_stride());
    runs = ($urandom_range(0, 4) == 0) ? 2 : 1;
    for (int r = 0; r < runs; r++) begin
      last = pick_vertex();
      axis = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        last[axis] = first[axis];
      end
      send_beat(MODE_SETUP, axis, last, pick_stride());
      n = $urandom_range(2, 12);
      for (int k = 0; k < n; k++) begin
        send_beat(MODE_STEP, 1'($urandom_range(0, 1)), pick_vertex(), pick_stride());
      end
    end
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // output side: random stalls, one long hold-off, none near the end
  initial begin : sink
    int n;
    bit hold_served;
    hold_served = 1'b0;
    m_tready    = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    beats_sent    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // nothing loaded yet: a step and a zero-span set-up against the reset vertex
    send_beat(MODE_STEP, 1'b1, pick_vertex(), Q_MAX);
    send_beat(MODE_SETUP, 1'b0, vtx6('0, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN), Q_MIN);
    send_beat(MODE_UNUSED, 1'b1, pick_vertex(), pick_stride());

    // full-range edge along x from the most negative corner
    send_beat(MODE_LOAD_START, 1'b1, {NUM_ATTRS{Q_MIN}}, Q_MAX);
    send_beat(MODE_SETUP, 1'b0, {NUM_ATTRS{Q_MAX}}, Q_MIN);
    send_beat(MODE_STEP, 1'b0, {NUM_ATTRS{Q_MAX}}, Q_ONE);
    send_beat(MODE_STEP, 1'b0, '0, Q_MAX);
    send_beat(MODE_STEP, 1'b0, '0, Q_MIN);
    send_beat(MODE_STEP, 1'b1, '0, '0);
    send_beat(MODE_STEP, 1'b0, '0, Q_ULP_DOWN);

    // one-lsb span along y: increments saturate both ways
    send_beat(MODE_LOAD_START, 1'b0, vtx6('0, '0, '0, Q_ONE, '0, Q_MAX), '0);
    send_beat(MODE_SETUP, 1'b1, vtx6(Q_MAX, 32'h1, Q_MIN, Q_MIN, 32'h12345678, Q_MIN), '0);
    send_beat(MODE_STEP, 1'b0, '0, Q_MAX);
    send_beat(MODE_STEP, 1'b0, '0, Q_MIN);
    send_beat(MODE_STEP, 1'b0, '0, Q_ULP_DOWN);
    send_beat(MODE_STEP, 1'b0, '0, Q_ONE);

    // zero span on y while every other field moves
    send_beat(MODE_LOAD_START, 1'b1,
              vtx6(32'h00050000, 32'h00030000, Q_ONE, '0, Q_MAX, Q_MIN), Q_ONE);
    send_beat(MODE_SETUP, 1'b1,
              vtx6(32'hfff00000, 32'h00030000, Q_MIN, Q_MAX, '0, Q_ONE), Q_MAX);
    send_beat(MODE_STEP, 1'b0, '0, Q_ONE);

    // negative span along y and backward steps
    send_beat(MODE_LOAD_START, 1'b0,
              vtx6(32'h00100000, Q_MAX, 32'h00020000, '0, Q_ONE, Q_NEG_ONE), '0);
    send_beat(MODE_SETUP, 1'b1,
              vtx6(32'hfff80000, Q_MIN, Q_NEG_ONE, Q_MAX, Q_MIN, 32'h00400000), '0);
    send_beat(MODE_STEP, 1'b1, '0, Q_NEG_ONE);
    send_beat(MODE_STEP, 1'b1, '0, 32'h00008000);
    send_beat(MODE_UNUSED, 1'b0, {NUM_ATTRS{Q_MAX}}, Q_MAX);

    while (beats_sent < TOTAL_ITEMS) begin
      if (!hold_req && beats_sent >= HOLD_AT) begin
        hold_req = 1'b1;
      end
      calm          = (beats_sent >= CALM_FROM);
      src_idle_pct  = pick_idle_pct();
      sink_idle_pct = pick_idle_pct();
      if ($urandom_range(0, 99) < 85) begin
        walk_random_edge();
      end else begin
        // noise: any mode, any fields, out of order
        repeat ($urandom_range(1, 4)) begin
          send_beat(MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    pick_vertex(), pick_stride());
        end
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run of %0d input beats: %0d start loads, %0d set-ups (%0d on a zero span),",
             beats_sent, start_loads, setups, flat_setups);
    $display("%0d steps, %0d unused-mode beats; %0d results compared, %0d mismatches",
             steps, unused_beats, beats_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
